[rtl/cspid_pkg.sv]
// Shared types and constants for the curvature scheduled PID speed controller.
`default_nettype none

package cspid_pkg;

  // Field widths fixed by the data formats
  localparam int SpeedW  = 16;  // Q7.8 speeds
  localparam int CurvW   = 16;  // Q2.13 curvature
  localparam int RegW    = 16;  // configuration registers
  localparam int ErrW    = 17;  // speed error, Q8.8
  localparam int GainW   = 17;  // scheduled gain, Q4.12
  localparam int IntegW  = 32;  // error integral, Q15.16
  localparam int CmdW    = 24;  // speed command, Q15.8
  localparam int RespW   = 16;  // response ROM entry, Q0.16
  localparam int CfgIdxW = 4;
  localparam int MulAW   = 36;
  localparam int MulBW   = 18;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = 56;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PROP_BASE  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_PROP_SPAN  = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_BASE = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_SPAN = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_BASE = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_SPAN = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIME  = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_INV_STEP   = 4'd7;

  // Configuration reset values
  localparam logic [RegW-1:0] PROP_BASE_RST  = 16'd4096;
  localparam logic [RegW-1:0] PROP_SPAN_RST  = 16'd12288;
  localparam logic [RegW-1:0] INTEG_BASE_RST = 16'd410;
  localparam logic [RegW-1:0] INTEG_SPAN_RST = 16'd819;
  localparam logic [RegW-1:0] DERIV_BASE_RST = 16'd2048;
  localparam logic [RegW-1:0] DERIV_SPAN_RST = 16'd4096;
  localparam logic [RegW-1:0] STEP_TIME_RST  = 16'd6554;
  localparam logic [RegW-1:0] INV_STEP_RST   = 16'd2560;

  typedef struct packed {
    logic [RegW-1:0] prop_gain_base;
    logic [RegW-1:0] prop_gain_span;
    logic [RegW-1:0] integ_gain_base;
    logic [RegW-1:0] integ_gain_span;
    logic [RegW-1:0] deriv_gain_base;
    logic [RegW-1:0] deriv_gain_span;
    logic [RegW-1:0] step_time;
    logic [RegW-1:0] inverse_step_time;
  } cspid_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROM,
    ST_GAIN_P,
    ST_GAIN_I,
    ST_GAIN_D,
    ST_INTEG,
    ST_PROP,
    ST_DIFF,
    ST_DERIV,
    ST_INT_TERM,
    ST_SUM,
    ST_OUT
  } cspid_state_t;

  typedef enum logic [2:0] {
    MUL_SPAN_P,
    MUL_SPAN_I,
    MUL_SPAN_D,
    MUL_ERR_STEP,
    MUL_KP_ERR,
    MUL_DIFF_INV,
    MUL_KD_DIFF,
    MUL_KI_INTEG
  } cspid_mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } cspid_acc_op_t;

  typedef struct packed {
    logic           capture;
    logic           rom_rd;
    cspid_mul_sel_t mul_sel;
    logic           ld_kp;
    logic           ld_ki;
    logic           ld_kd;
    logic           ld_integ;
    cspid_acc_op_t  acc_op;
    logic           ld_out;
  } cspid_cmd_t;

endpackage

`default_nettype wire

[rtl/cspid_cfg.sv]
// Configuration register file for the PID gains and step time.
`default_nettype none

module cspid_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cspid_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [cspid_pkg::RegW-1:0]      cfg_data,
  output cspid_pkg::cspid_cfg_t                cfg_regs
);
  import cspid_pkg::*;

  cspid_cfg_t regs_r;
  cspid_cfg_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_regs  = regs_r;

  // Decode the write index; drop writes beyond the register list
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROP_BASE:  regs_nxt.prop_gain_base    = cfg_data;
        CFG_PROP_SPAN:  regs_nxt.prop_gain_span    = cfg_data;
        CFG_INTEG_BASE: regs_nxt.integ_gain_base   = cfg_data;
        CFG_INTEG_SPAN: regs_nxt.integ_gain_span   = cfg_data;
        CFG_DERIV_BASE: regs_nxt.deriv_gain_base   = cfg_data;
        CFG_DERIV_SPAN: regs_nxt.deriv_gain_span   = cfg_data;
        CFG_STEP_TIME:  regs_nxt.step_time         = cfg_data;
        CFG_INV_STEP:   regs_nxt.inverse_step_time = cfg_data;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.prop_gain_base    <= PROP_BASE_RST;
      regs_r.prop_gain_span    <= PROP_SPAN_RST;
      regs_r.integ_gain_base   <= INTEG_BASE_RST;
      regs_r.integ_gain_span   <= INTEG_SPAN_RST;
      regs_r.deriv_gain_base   <= DERIV_BASE_RST;
      regs_r.deriv_gain_span   <= DERIV_SPAN_RST;
      regs_r.step_time         <= STEP_TIME_RST;
      regs_r.inverse_step_time <= INV_STEP_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/cspid_ctrl.sv]
// Sequencer for the gain schedule and PID step over one shared multiplier.
`default_nettype none

module cspid_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output cspid_pkg::cspid_cmd_t cmd
);
  import cspid_pkg::*;

  cspid_state_t state_r;
  cspid_state_t state_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_ROM;
      ST_ROM:      state_nxt = ST_GAIN_P;
      ST_GAIN_P:   state_nxt = ST_GAIN_I;
      ST_GAIN_I:   state_nxt = ST_GAIN_D;
      ST_GAIN_D:   state_nxt = ST_INTEG;
      ST_INTEG:    state_nxt = ST_PROP;
      ST_PROP:     state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_DERIV;
      ST_DERIV:    state_nxt = ST_INT_TERM;
      ST_INT_TERM: state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_SPAN_P;
    cmd.acc_op   = ACC_HOLD;
    unique case (state_r)
      ST_IDLE:     cmd.capture = in_tvalid;
      ST_ROM:      cmd.rom_rd  = 1'b1;
      ST_GAIN_P:   cmd.mul_sel = MUL_SPAN_P;
      ST_GAIN_I: begin
        cmd.ld_kp   = 1'b1;
        cmd.mul_sel = MUL_SPAN_I;
      end
      ST_GAIN_D: begin
        cmd.ld_ki   = 1'b1;
        cmd.mul_sel = MUL_SPAN_D;
      end
      ST_INTEG: begin
        cmd.ld_kd   = 1'b1;
        cmd.mul_sel = MUL_ERR_STEP;
      end
      ST_PROP: begin
        cmd.ld_integ = 1'b1;
        cmd.mul_sel  = MUL_KP_ERR;
      end
      ST_DIFF: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MUL_DIFF_INV;
      end
      ST_DERIV:    cmd.mul_sel = MUL_KD_DIFF;
      ST_INT_TERM: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MUL_KI_INTEG;
      end
      ST_SUM:      cmd.acc_op = ACC_ADD;
      ST_OUT:      cmd.ld_out = out_free;
      default:     cmd = '0;
    endcase
  end

  // Output beat valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.ld_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/cspid_dp.sv]
// Datapath: response ROM, shared multiplier, integral, accumulator, output register.
`default_nettype none

module cspid_dp #(
  parameter int RESPONSE_TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cspid_pkg::cspid_cmd_t         cmd,
  input  wire cspid_pkg::cspid_cfg_t         cfg_regs,
  input  wire logic [cspid_pkg::SpeedW-1:0]  reference_speed,
  input  wire logic [cspid_pkg::SpeedW-1:0]  measured_speed,
  input  wire logic [cspid_pkg::CurvW-1:0]   path_curvature,
  output logic [cspid_pkg::CmdW-1:0]         speed_command,
  output logic                               saturated
);
  import cspid_pkg::*;

  localparam int IdxW    = $clog2(RESPONSE_TABLE_DEPTH);
  localparam int ScaleW  = CurvW + 1 + IdxW + 1;
  localparam int IdxShift = 12;
  localparam longint unsigned OneQ30 = 64'd1 << 30;

  // Shift-and-subtract quotient, used only while building the constant table
  function automatic longint unsigned const_udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-10/DEPTH) in Q0.30 from a Taylor series through the 12th power
  function automatic longint unsigned exp_step();
    longint unsigned term;
    longint unsigned q;
    term = OneQ30;
    q    = OneQ30;
    for (int n = 1; n <= 12; n++) begin
      term = const_udiv(term * 64'd10, 64'(RESPONSE_TABLE_DEPTH) * 64'(n));
      if (n[0]) q = q - term;
      else      q = q + term;
    end
    return q;
  endfunction

  localparam longint unsigned QStep = exp_step();

  // Entry i: tanh(5*i/DEPTH) in Q0.16, with p stepped down by QStep i times
  function automatic logic [RespW-1:0] rom_entry(int i);
    longint unsigned p;
    longint unsigned v;
    p = OneQ30;
    for (int k = 0; k < i; k++) p = (p * QStep) >> 30;
    v = const_udiv((OneQ30 - p) << 16, OneQ30 + p);
    return (v > 64'd65535) ? 16'hFFFF : v[RespW-1:0];
  endfunction

  logic [RespW-1:0]           resp_rom [RESPONSE_TABLE_DEPTH];

  // Constant response table
  for (genvar g = 0; g < RESPONSE_TABLE_DEPTH; g++) begin : g_rom
    assign resp_rom[g] = rom_entry(g);
  end

  logic [IdxW-1:0]            idx_r;
  logic [RespW-1:0]           resp_r;
  logic signed [ErrW-1:0]     err_r;
  logic signed [ErrW-1:0]     prev_err_r;
  logic [GainW-1:0]           kp_r;
  logic [GainW-1:0]           ki_r;
  logic [GainW-1:0]           kd_r;
  logic signed [IntegW-1:0]   integ_r;
  logic                       integ_sat_r;
  logic signed [ProdW-1:0]    prod_r;
  logic signed [AccW-1:0]     acc_r;
  logic [CmdW-1:0]            cmd_out_r;
  logic                       sat_out_r;

  logic [CurvW:0]             curv_mag;
  logic [ScaleW-1:0]          curv_scaled;
  logic [ScaleW-1:0]          idx_wide;
  logic [IdxW-1:0]            idx_nxt;
  logic signed [ErrW-1:0]     err_nxt;
  logic signed [ErrW:0]       err_diff;
  logic signed [MulAW-1:0]    mul_a;
  logic signed [MulBW-1:0]    mul_b;
  logic [GainW-1:0]           gain_nxt;
  logic signed [IntegW+1:0]   integ_ext;
  logic signed [IntegW+1:0]   integ_inc;
  logic signed [IntegW+1:0]   integ_sum;
  logic                       integ_ovf;
  logic signed [IntegW-1:0]   integ_nxt;
  logic                       cmd_ovf;
  logic [CmdW-1:0]            cmd_nxt;

  // Curvature magnitude to ROM index, clamped to the last entry
  always_comb begin
    curv_mag    = path_curvature[CurvW-1] ? ((CurvW+1)'(0) - {1'b1, path_curvature})
                                          : {1'b0, path_curvature};
    curv_scaled = ScaleW'(curv_mag) * ScaleW'(RESPONSE_TABLE_DEPTH);
    idx_wide    = curv_scaled >> IdxShift;
    if (idx_wide > ScaleW'(RESPONSE_TABLE_DEPTH - 1))
      idx_nxt = IdxW'(RESPONSE_TABLE_DEPTH - 1);
    else
      idx_nxt = idx_wide[IdxW-1:0];
  end

  assign err_nxt  = $signed({reference_speed[SpeedW-1], reference_speed})
                  - $signed({measured_speed[SpeedW-1], measured_speed});
  assign err_diff = $signed({err_r[ErrW-1], err_r}) - $signed({prev_err_r[ErrW-1], prev_err_r});

  // Multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SPAN_P: begin
        mul_a = $signed({20'd0, cfg_regs.prop_gain_span});
        mul_b = $signed({2'd0, resp_r});
      end
      MUL_SPAN_I: begin
        mul_a = $signed({20'd0, cfg_regs.integ_gain_span});
        mul_b = $signed({2'd0, resp_r});
      end
      MUL_SPAN_D: begin
        mul_a = $signed({20'd0, cfg_regs.deriv_gain_span});
        mul_b = $signed({2'd0, resp_r});
      end
      MUL_ERR_STEP: begin
        mul_a = $signed({{(MulAW-ErrW){err_r[ErrW-1]}}, err_r});
        mul_b = $signed({2'd0, cfg_regs.step_time});
      end
      MUL_KP_ERR: begin
        mul_a = $signed({{(MulAW-ErrW){err_r[ErrW-1]}}, err_r});
        mul_b = $signed({1'b0, kp_r});
      end
      MUL_DIFF_INV: begin
        mul_a = $signed({{(MulAW-ErrW-1){err_diff[ErrW]}}, err_diff});
        mul_b = $signed({2'd0, cfg_regs.inverse_step_time});
      end
      MUL_KD_DIFF: begin
        mul_a = prod_r[MulAW-1:0];
        mul_b = $signed({1'b0, kd_r});
      end
      MUL_KI_INTEG: begin
        mul_a = $signed({{(MulAW-IntegW){integ_r[IntegW-1]}}, integ_r});
        mul_b = $signed({1'b0, ki_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Scheduled gain: base plus the upper half of span times response
  assign gain_nxt = {1'b0, prod_r[31:16]} + GainW'(
                    cmd.ld_kp ? cfg_regs.prop_gain_base :
                    cmd.ld_ki ? cfg_regs.integ_gain_base : cfg_regs.deriv_gain_base);

  // Integral update with saturation to 32 bits
  always_comb begin
    integ_ext = $signed({{2{integ_r[IntegW-1]}}, integ_r});
    integ_inc = $signed(prod_r[IntegW+9:8]);
    integ_sum = integ_ext + integ_inc;
    integ_ovf = !((&integ_sum[IntegW+1:IntegW-1]) || !(|integ_sum[IntegW+1:IntegW-1]));
    if (integ_ovf)
      integ_nxt = integ_sum[IntegW+1] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    else
      integ_nxt = integ_sum[IntegW-1:0];
  end

  // Command: floor of the sum by 2^20, clamped to 24 bits
  always_comb begin
    cmd_ovf = !((&acc_r[AccW-1:CmdW+19]) || !(|acc_r[AccW-1:CmdW+19]));
    if (cmd_ovf)
      cmd_nxt = acc_r[AccW-1] ? {1'b1, {(CmdW-1){1'b0}}} : {1'b0, {(CmdW-1){1'b1}}};
    else
      cmd_nxt = acc_r[CmdW+19:20];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.capture) begin
      idx_r <= idx_nxt;
      err_r <= err_nxt;
    end
    if (cmd.rom_rd) resp_r <= resp_rom[idx_r];
    if (cmd.ld_kp)  kp_r   <= gain_nxt;
    if (cmd.ld_ki)  ki_r   <= gain_nxt;
    if (cmd.ld_kd)  kd_r   <= gain_nxt;
    if (cmd.ld_integ) integ_sat_r <= integ_ovf;
    unique case (cmd.acc_op)
      ACC_LOAD: acc_r <= {prod_r[AccW-9:0], 8'd0};
      ACC_ADD:  acc_r <= acc_r + {{(AccW-ProdW){prod_r[ProdW-1]}}, prod_r};
      default:  acc_r <= acc_r;
    endcase
    if (cmd.ld_out) begin
      cmd_out_r <= cmd_nxt;
      sat_out_r <= integ_sat_r | cmd_ovf;
    end
  end

  // Controller state carried across ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (cmd.ld_integ) integ_r    <= integ_nxt;
      if (cmd.ld_out)   prev_err_r <= err_r;
    end
  end

  assign speed_command = cmd_out_r;
  assign saturated     = sat_out_r;

endmodule

`default_nettype wire

[rtl/curvature_scheduled_pid_speed.sv]
// Top level of the curvature scheduled PID speed controller.
//
//  channel | direction | beat contents (tdata, lowest bit first)
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | reference_speed[15:0], measured_speed[15:0],
//          |           | path_curvature[15:0]
//  out_    | master    | speed_command[23:0], saturated[0], zero pad to 32 bits
//  cfg_    | slave     | cfg_index selects the register, cfg_data is the value
//
// Each tick runs from input beat to output beat through one input capture,
// one ROM read, then nine steps through a single 36x18 multiplier, then the
// output load. Reset clears the integral, the previous error, the state and
// the output valid. The next input beat is taken once the result is loaded
// into the output register, even while that beat waits on out_tready; the
// final load stalls only while an earlier result is still unread.
`default_nettype none

module curvature_scheduled_pid_speed #(
  parameter int RESPONSE_TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [47:0]                   in_tdata,   // reference, measured, curvature
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [31:0]                        out_tdata,  // speed_command, saturated, pad
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cspid_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cspid_pkg::RegW-1:0]    cfg_data
);
  import cspid_pkg::*;

  cspid_cmd_t     cmd;
  cspid_cfg_t     cfg_regs;
  logic [CmdW-1:0] speed_command;
  logic           saturated;

  cspid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_regs  (cfg_regs)
  );

  cspid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cspid_dp #(
    .RESPONSE_TABLE_DEPTH (RESPONSE_TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_regs        (cfg_regs),
    .reference_speed (in_tdata[15:0]),
    .measured_speed  (in_tdata[31:16]),
    .path_curvature  (in_tdata[47:32]),
    .speed_command   (speed_command),
    .saturated       (saturated)
  );

  assign out_tdata = {7'd0, saturated, speed_command};

endmodule

`default_nettype wire
